// ===== hdl/rdsl_pkg.sv =====
// Shared types, codes and constants of the ramped duty motor channel with stall lockout.
package rdsl_pkg;

	localparam int PWM_COUNTS      = 4800;
	localparam int STALL_DELTA_MIN = 2;
	localparam int RAMP_TOLERANCE  = 24;

	localparam int DUTY_W = 13;
	localparam int SDUTY_W = 14;
	localparam int WORD_W = 32;
	localparam int MS_W = 16;
	localparam int STILL_W = 17;
	localparam int DT_W = 7;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W = 80;
	localparam int OUT_DATA_W = 48;

	// Elapsed time used on the first check and after a long gap between checks.
	localparam logic [DT_W-1:0] DT_DEFAULT_MS = DT_W'(5);
	localparam logic [WORD_W-1:0] DT_LIMIT_MS = WORD_W'(100);

	localparam logic [16:0] PWM_COUNTS_V = 17'(PWM_COUNTS);
	localparam logic [WORD_W-1:0] DELTA_MIN_V = WORD_W'(STALL_DELTA_MIN);
	localparam logic [DUTY_W-1:0] RAMP_TOL_V = DUTY_W'(RAMP_TOLERANCE);

	typedef enum logic [3:0] {
		K_SET_DUTY     = 4'd0,
		K_SET_SIGNED   = 4'd1,
		K_SET_DIR      = 4'd2,
		K_RAMP_TICK    = 4'd3,
		K_STALL_CHECK  = 4'd4,
		K_STOP         = 4'd5,
		K_ESTOP        = 4'd6,
		K_RESET_LOCK   = 4'd7,
		K_ENABLE       = 4'd8,
		K_DISABLE      = 4'd9
	} kind_t;

	typedef enum logic [1:0] {
		DIR_STOP  = 2'd0,
		DIR_CW    = 2'd1,
		DIR_CCW   = 2'd2,
		DIR_BRAKE = 2'd3
	} dir_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_DUAL_PWM     = 3'd0,
		REG_MAX_DUTY     = 3'd1,
		REG_RAMP_STEP    = 3'd2,
		REG_DEAD_BAND    = 3'd3,
		REG_STALL_THRESH = 3'd4,
		REG_STALL_WINDOW = 3'd5,
		REG_LOCKOUT      = 3'd6,
		REG_STALL_EN     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic              dual_pwm;
		logic [DUTY_W-1:0] max_duty;
		logic [DUTY_W-1:0] ramp_step;
		logic [DUTY_W-1:0] dead_band;
		logic [DUTY_W-1:0] stall_thresh;
		logic [MS_W-1:0]   stall_window;
		logic [MS_W-1:0]   lockout_ms;
		logic              stall_en;
	} cfg_t;

	typedef struct packed {
		logic [3:0]                kind;
		logic signed [SDUTY_W-1:0] duty_value;
		logic [1:0]                direction;
		logic [WORD_W-1:0]         enc_count;
		logic [WORD_W-1:0]         now_ms;
	} item_t;

	typedef struct packed {
		logic [DUTY_W-1:0]         compare_a;
		logic [DUTY_W-1:0]         compare_b;
		logic                      dir_pin_one;
		logic                      dir_pin_two;
		logic                      bridge_enable;
		logic                      stalled;
		logic                      stall_event;
		logic signed [SDUTY_W-1:0] signed_duty;
	} result_t;

endpackage

// ===== hdl/rdsl_core.sv =====
// Channel state registers and the single-pass command logic that updates them.
module rdsl_core
	import rdsl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	logic [DUTY_W-1:0]         cur_q, target_q, pwm_a_q, pwm_b_q;
	logic signed [SDUTY_W-1:0] last_signed_q;
	logic [1:0]                dir_q;
	logic                      pin_one_q, pin_two_q, enable_q, locked_q;
	logic [WORD_W-1:0]         lock_end_q, ref_pos_q, last_check_q;
	logic [STILL_W-1:0]        still_q;

	logic [DUTY_W-1:0]         n_cur, n_target, n_a, n_b;
	logic signed [SDUTY_W-1:0] n_last;
	logic [1:0]                n_dir;
	logic                      n_pin_one, n_pin_two, n_enable, n_locked, n_event;
	logic [WORD_W-1:0]         n_lock_end, n_ref_pos, n_last_check;
	logic [STILL_W-1:0]        n_still;

	logic [DUTY_W-1:0]         cap, sd_duty, sd_gap, ramp_gap, step, ramp_duty, mag;
	logic signed [SDUTY_W:0]   sg_wide, cap_s;
	logic signed [SDUTY_W-1:0] sg_duty;
	logic                      sg_neg;
	logic [1:0]                sg_dir;
	logic [WORD_W-1:0]         dt_raw, enc_diff, enc_ndiff;
	logic [DT_W-1:0]           dt;
	logic [STILL_W-1:0]        still_sum;
	logic                      enc_still, unlock;

	// Compare for the forward output after applying a duty.
	function automatic logic [DUTY_W-1:0] apply_a(input logic dual, input logic [1:0] dir,
			input logic [DUTY_W-1:0] d);
		if (dual) begin
			return (dir == DIR_CW) ? d : '0;
		end
		return d;
	endfunction

	// Compare for the reverse output; single-PWM use leaves it as it was.
	function automatic logic [DUTY_W-1:0] apply_b(input logic dual, input logic [1:0] dir,
			input logic [DUTY_W-1:0] d, input logic [DUTY_W-1:0] old);
		if (dual) begin
			return (dir == DIR_CCW) ? d : '0;
		end
		return old;
	endfunction

	// Operands shared by several commands.
	always_comb begin
		cap = ({4'b0, cfg.max_duty} < PWM_COUNTS_V) ? cfg.max_duty : PWM_COUNTS_V[DUTY_W-1:0];

		// Unsigned duty request, clamped into zero to cap.
		if (item.duty_value < 0) begin
			sd_duty = '0;
		end else if (item.duty_value[DUTY_W-1:0] > cap) begin
			sd_duty = cap;
		end else begin
			sd_duty = item.duty_value[DUTY_W-1:0];
		end
		sd_gap = (sd_duty > cur_q) ? sd_duty - cur_q : cur_q - sd_duty;

		// Signed duty request, clamped into minus cap to cap.
		cap_s = signed'({2'b00, cap});
		sg_wide = SDUTY_W'(item.duty_value);
		sg_wide = {item.duty_value[SDUTY_W-1], item.duty_value};
		if (sg_wide > cap_s) begin
			sg_wide = cap_s;
		end else if (sg_wide < -cap_s) begin
			sg_wide = -cap_s;
		end
		sg_duty = sg_wide[SDUTY_W-1:0];
		sg_neg = sg_wide[SDUTY_W];
		mag = sg_neg ? DUTY_W'(-sg_wide) : sg_wide[DUTY_W-1:0];
		sg_dir = sg_neg ? DIR_CCW : DIR_CW;

		// One ramp step towards the target.
		step = (cfg.ramp_step == '0) ? DUTY_W'(1) : cfg.ramp_step;
		ramp_gap = (cur_q > target_q) ? cur_q - target_q : target_q - cur_q;
		if (ramp_gap <= step) begin
			ramp_duty = target_q;
		end else if (cur_q < target_q) begin
			ramp_duty = cur_q + step;
		end else begin
			ramp_duty = cur_q - step;
		end

		// Elapsed time since the last check and encoder movement since the reference.
		dt_raw = item.now_ms - last_check_q;
		if (last_check_q == '0 || dt_raw > DT_LIMIT_MS) begin
			dt = DT_DEFAULT_MS;
		end else begin
			dt = dt_raw[DT_W-1:0];
		end
		still_sum = still_q + STILL_W'(dt);
		enc_diff = item.enc_count - ref_pos_q;
		enc_ndiff = '0 - enc_diff;
		enc_still = (enc_diff < DELTA_MIN_V) || (enc_ndiff < DELTA_MIN_V);
		unlock = locked_q && (item.now_ms >= lock_end_q);
	end

	// Next state for one command.
	always_comb begin
		n_cur = cur_q;
		n_target = target_q;
		n_a = pwm_a_q;
		n_b = pwm_b_q;
		n_last = last_signed_q;
		n_dir = dir_q;
		n_pin_one = pin_one_q;
		n_pin_two = pin_two_q;
		n_enable = enable_q;
		n_locked = locked_q;
		n_lock_end = lock_end_q;
		n_ref_pos = ref_pos_q;
		n_last_check = last_check_q;
		n_still = still_q;
		n_event = 1'b0;

		unique case (item.kind)
			K_SET_DUTY: begin
				if (!locked_q) begin
					n_target = sd_duty;
					if (sd_gap <= cfg.dead_band) begin
						n_cur = sd_duty;
						n_a = apply_a(cfg.dual_pwm, dir_q, sd_duty);
						n_b = apply_b(cfg.dual_pwm, dir_q, sd_duty, pwm_b_q);
					end
				end
			end
			K_SET_SIGNED: begin
				if (!locked_q) begin
					if (cfg.dual_pwm) begin
						n_dir = sg_dir;
					end else begin
						n_pin_one = !sg_neg;
						n_pin_two = sg_neg;
					end
					n_cur = mag;
					n_target = mag;
					n_last = sg_duty;
					n_a = apply_a(cfg.dual_pwm, n_dir, mag);
					n_b = apply_b(cfg.dual_pwm, n_dir, mag, pwm_b_q);
				end
			end
			K_SET_DIR: begin
				if (cfg.dual_pwm) begin
					n_dir = item.direction;
					n_a = '0;
					n_b = '0;
				end else begin
					n_pin_one = (item.direction == DIR_CW) || (item.direction == DIR_BRAKE);
					n_pin_two = (item.direction == DIR_CCW) || (item.direction == DIR_BRAKE);
				end
			end
			K_RAMP_TICK: begin
				if (cur_q != target_q) begin
					n_cur = ramp_duty;
					n_a = apply_a(cfg.dual_pwm, dir_q, ramp_duty);
					n_b = apply_b(cfg.dual_pwm, dir_q, ramp_duty, pwm_b_q);
				end
			end
			K_STALL_CHECK: begin
				if (!cfg.stall_en) begin
					if (locked_q) begin
						n_locked = 1'b0;
						n_lock_end = '0;
						n_enable = 1'b1;
					end
					n_still = '0;
					n_ref_pos = item.enc_count;
					n_last_check = item.now_ms;
				end else begin
					if (unlock) begin
						n_locked = 1'b0;
						n_lock_end = '0;
						n_enable = 1'b1;
					end
					n_last_check = item.now_ms;
					if ((locked_q && !unlock) || (ramp_gap > RAMP_TOL_V)
							|| (cur_q <= cfg.stall_thresh) || !enc_still) begin
						n_still = '0;
						n_ref_pos = item.enc_count;
					end else if (still_sum >= {1'b0, cfg.stall_window}) begin
						// Stall declared: emergency stop and start the lockout.
						n_still = '0;
						n_ref_pos = item.enc_count;
						n_lock_end = item.now_ms + WORD_W'(cfg.lockout_ms);
						n_enable = 1'b0;
						n_target = '0;
						n_cur = '0;
						n_last = '0;
						n_a = '0;
						if (cfg.dual_pwm) begin
							n_b = '0;
						end else begin
							n_pin_one = 1'b0;
							n_pin_two = 1'b0;
						end
						n_locked = 1'b1;
						n_event = 1'b1;
					end else begin
						n_still = still_sum;
					end
				end
			end
			K_STOP: begin
				if (cfg.dual_pwm) begin
					n_dir = DIR_STOP;
					n_b = '0;
				end else begin
					n_pin_one = 1'b0;
					n_pin_two = 1'b0;
				end
				n_target = '0;
				n_cur = '0;
				n_last = '0;
				n_a = '0;
			end
			K_ESTOP: begin
				n_enable = 1'b0;
				n_target = '0;
				n_cur = '0;
				n_last = '0;
				n_a = '0;
				if (cfg.dual_pwm) begin
					n_b = '0;
				end else begin
					n_pin_one = 1'b0;
					n_pin_two = 1'b0;
				end
			end
			K_RESET_LOCK: begin
				n_locked = 1'b0;
				n_lock_end = '0;
				n_still = '0;
				n_enable = 1'b1;
			end
			K_ENABLE: begin
				if (!locked_q) begin
					n_enable = 1'b1;
				end
			end
			K_DISABLE: begin
				n_enable = 1'b0;
			end
			default: begin
				// Unused command codes change nothing.
			end
		endcase
	end

	// State registers, updated once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			target_q <= '0;
			pwm_a_q <= '0;
			pwm_b_q <= '0;
			last_signed_q <= '0;
			dir_q <= DIR_STOP;
			pin_one_q <= 1'b0;
			pin_two_q <= 1'b0;
			enable_q <= 1'b0;
			locked_q <= 1'b0;
			lock_end_q <= '0;
			ref_pos_q <= '0;
			last_check_q <= '0;
			still_q <= '0;
		end else if (fire) begin
			cur_q <= n_cur;
			target_q <= n_target;
			pwm_a_q <= n_a;
			pwm_b_q <= n_b;
			last_signed_q <= n_last;
			dir_q <= n_dir;
			pin_one_q <= n_pin_one;
			pin_two_q <= n_pin_two;
			enable_q <= n_enable;
			locked_q <= n_locked;
			lock_end_q <= n_lock_end;
			ref_pos_q <= n_ref_pos;
			last_check_q <= n_last_check;
			still_q <= n_still;
		end
	end

	// Result of the command in flight.
	assign res = '{compare_a: n_a, compare_b: n_b, dir_pin_one: n_pin_one,
		dir_pin_two: n_pin_two, bridge_enable: n_enable, stalled: n_locked,
		stall_event: n_event, signed_duty: n_last};

endmodule

// ===== hdl/ramped_duty_with_stall_lockout.sv =====
// Top level of the ramped duty H-bridge channel: stream ports, configuration and pipeline.
//
// Usage: each input transaction on the s_ channel is one command (s_tuser holds the
// command code, s_tdata its operands); every command gives exactly one result
// transaction on the m_ channel carrying the PWM compares, direction pins, bridge
// enable, lockout flag, stall pulse and the last signed duty.
// A command is held in the input register, where the command logic updates the channel
// state, and its result is then shown from the result register. Throughput is one
// command per cycle while the receiver does not stall: the state
// update is one short pass of compares and adds between those two registers.
// When the receiver stalls, the result register holds its transaction, the input
// register keeps one more command, and s_tready drops only while both are full.
// Configuration writes on cfg_we/cfg_addr/cfg_wdata take effect at once and should
// be made only while no command is in flight.
// Reset (arst_n low) clears both registers' valid flags, sets every configuration
// register to its default and clears all channel state: duty zero, direction stop,
// bridge disabled and no lockout.
module ramped_duty_with_stall_lockout
	import rdsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// duty_value[13:0], direction[15:14], enc_count[47:16], now_ms[79:48]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// kind[3:0]
	input  logic [3:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// compare_a[12:0], compare_b[25:13], dir_pin_one[26], dir_pin_two[27],
	// bridge_enable[28], stalled[29], stall_event[30], signed_duty[44:31], zero[47:45]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_next, res_q;
	logic    out_valid_q;
	logic    advance, take_in;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dual_pwm <= 1'b0;
			cfg_q.max_duty <= DUTY_W'(2400);
			cfg_q.ramp_step <= DUTY_W'(48);
			cfg_q.dead_band <= DUTY_W'(480);
			cfg_q.stall_thresh <= DUTY_W'(960);
			cfg_q.stall_window <= MS_W'(200);
			cfg_q.lockout_ms <= MS_W'(1000);
			cfg_q.stall_en <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				REG_DUAL_PWM:     cfg_q.dual_pwm <= cfg_wdata[0];
				REG_MAX_DUTY:     cfg_q.max_duty <= cfg_wdata[DUTY_W-1:0];
				REG_RAMP_STEP:    cfg_q.ramp_step <= cfg_wdata[DUTY_W-1:0];
				REG_DEAD_BAND:    cfg_q.dead_band <= cfg_wdata[DUTY_W-1:0];
				REG_STALL_THRESH: cfg_q.stall_thresh <= cfg_wdata[DUTY_W-1:0];
				REG_STALL_WINDOW: cfg_q.stall_window <= cfg_wdata;
				REG_LOCKOUT:      cfg_q.lockout_ms <= cfg_wdata;
				REG_STALL_EN:     cfg_q.stall_en <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the command in the input register moves on when the result slot frees.
	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take_in = s_tvalid && s_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{kind: s_tuser, duty_value: s_tdata[13:0], direction: s_tdata[15:14],
				enc_count: s_tdata[47:16], now_ms: s_tdata[79:48]};
		end
	end

	rdsl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.fire   (advance),
		.item   (item_s1),
		.res    (res_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, res_q.signed_duty, res_q.stall_event, res_q.stalled,
		res_q.bridge_enable, res_q.dir_pin_two, res_q.dir_pin_one, res_q.compare_b,
		res_q.compare_a};

	// A stall pulse always comes with the lockout set and the bridge stopped.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.stall_event) |->
			(res_q.stalled && !res_q.bridge_enable && res_q.compare_a == '0))
		else $error("stall event without lockout and stop");

	// While locked out, no signed duty can have been applied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.stalled) |-> (res_q.signed_duty == '0))
		else $error("signed duty applied during lockout");

	// Input is refused only when both registers hold a transaction and the sink stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input refused with room in the pipeline");

	// A command that moves on is shown as a result on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result lost after command advanced");

endmodule
